FILE: rtl/core/mptl_pkg.sv
// ----------------------------------------------------------------------------
// MAC port table package
// Shared sizes, command and status codes and the sequencer state type for
// the MAC-to-port table with longest-prefix lookup.
// ----------------------------------------------------------------------------
package mptl_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int MAC_DIGITS  = 12;

  // Field widths
  localparam int MAC_W    = 48;
  localparam int PORT_W   = 8;
  localparam int STATUS_W = 3;
  localparam int MATCH_W  = 4;

  // Derived widths
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int KEY_W = 4 * MAC_DIGITS;
  localparam int LEN_W = $clog2(MAC_DIGITS + 1);

  // Commands
  localparam logic CMD_ASSIGN = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_PORT_USED = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_MAC_USED  = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_FOUND     = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd5;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

FILE: rtl/core/mac_port_table_prefix_lookup.sv
// ----------------------------------------------------------------------------
// MAC port table with longest-prefix lookup
// Binds 48-bit MAC addresses to distinct 8-bit ports and answers lookups
// with the port of the entry sharing the longest run of leading hex digits.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low. Every command
// then walks the whole table, one entry per clock, through a single shared
// compare unit (digit-prefix length, MAC magnitude compare, port compare):
// the beat is taken in ST_IDLE, every entry is compared in ST_SCAN, ST_FINISH
// resolves the result and writes the table, and the result is shown once the
// sequencer is back in ST_IDLE, where the next beat can already be taken.
// The result beat is shown on status, out_port and match_digits for exactly
// one cycle with done high; there is no back pressure, so the receiver must
// capture it in that cycle. The table is empty after reset and needs no
// clearing pass.
module mac_port_table_prefix_lookup (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         cmd,
  input  logic [mptl_pkg::MAC_W-1:0]   mac,
  input  logic [mptl_pkg::PORT_W-1:0]  port,
  output logic                         done,
  output logic [mptl_pkg::STATUS_W-1:0] status,
  output logic [mptl_pkg::PORT_W-1:0]  out_port,
  output logic [mptl_pkg::MATCH_W-1:0] match_digits
);
  import mptl_pkg::*;

  // Table storage
  logic [TABLE_DEPTH-1:0] entry_valid;
  logic [MAC_W-1:0]       entry_mac  [TABLE_DEPTH];
  logic [PORT_W-1:0]      entry_port [TABLE_DEPTH];

  // Sequencer
  state_t           state, state_next;
  logic [IDX_W-1:0] idx;
  logic             accept;
  logic             last;

  // Captured command
  logic              cmd_q;
  logic [MAC_W-1:0]  mac_q;
  logic [PORT_W-1:0] port_q;

  // Running best candidate (conflict on assign, best match on lookup)
  logic              cand_valid;
  logic [MAC_W-1:0]  cand_mac;
  logic [PORT_W-1:0] cand_port;
  logic [LEN_W-1:0]  cand_len;

  // Lowest free slot
  logic             free_valid;
  logic [IDX_W-1:0] free_idx;

  // Shared compare unit outputs
  logic              cur_valid;
  logic [MAC_W-1:0]  cur_mac;
  logic [PORT_W-1:0] cur_port;
  logic [LEN_W-1:0]  cur_len;
  logic              cur_less;
  logic              cur_take;
  logic [KEY_W-1:0]  key_a, key_b;
  logic              run;

  // Resolve outputs
  logic [STATUS_W-1:0] res_status;
  logic                res_write;
  logic [LEN_W+3:0]    len_ext;
  logic [MATCH_W-1:0]  len_sat;

  // MAC as a key of MAC_DIGITS hex digits, zero above bit 47
  function automatic logic [KEY_W-1:0] to_key(input logic [MAC_W-1:0] m);
    logic [KEY_W+MAC_W-1:0] wide;
    wide = {{KEY_W{1'b0}}, m};
    return wide[KEY_W-1:0];
  endfunction

  assign accept = start && !busy;
  assign last   = (idx == IDX_W'(TABLE_DEPTH - 1));

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake
  always_comb begin
    state_next = state;
    busy       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (last) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Entry read at the scan index
  assign cur_valid = entry_valid[idx];
  assign cur_mac   = entry_mac[idx];
  assign cur_port  = entry_port[idx];

  // Shared compare unit: leading equal digits and MAC magnitude
  always_comb begin
    key_a   = to_key(mac_q);
    key_b   = to_key(cur_mac);
    run     = 1'b1;
    cur_len = '0;
    for (int d = 0; d < MAC_DIGITS; d++) begin
      if (run && (key_a[4*(MAC_DIGITS-1-d) +: 4] == key_b[4*(MAC_DIGITS-1-d) +: 4])) begin
        cur_len = cur_len + LEN_W'(1);
      end else begin
        run = 1'b0;
      end
    end
    cur_less = (cur_mac < cand_mac);
  end

  // Does this entry replace the candidate
  always_comb begin
    cur_take = 1'b0;
    if (cur_valid) begin
      if (cmd_q == CMD_ASSIGN) begin
        cur_take = ((cur_port == port_q) || (cur_mac == mac_q)) &&
                   (!cand_valid || cur_less);
      end else begin
        cur_take = (cur_len != '0) &&
                   (!cand_valid || (cur_len > cand_len) ||
                    ((cur_len == cand_len) && cur_less));
      end
    end
  end

  // Resolve the result from the scan
  always_comb begin
    res_write = 1'b0;
    if (cmd_q == CMD_ASSIGN) begin
      priority if (cand_valid) begin
        res_status = (cand_port == port_q) ? STATUS_PORT_USED : STATUS_MAC_USED;
      end else if (!free_valid) begin
        res_status = STATUS_FULL;
      end else begin
        res_status = STATUS_INSERTED;
        res_write  = 1'b1;
      end
    end else begin
      res_status = cand_valid ? STATUS_FOUND : STATUS_NOT_FOUND;
    end
    len_ext = (LEN_W+4)'(cand_len);
    len_sat = (len_ext > (LEN_W+4)'(15)) ? 4'hF : len_ext[3:0];
  end

  // Control registers: scan index, flags, table valid bits, result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      idx         <= '0;
      cand_valid  <= 1'b0;
      free_valid  <= 1'b0;
      entry_valid <= '0;
      done        <= 1'b0;
    end else begin
      done <= (state == ST_FINISH);
      if (accept) begin
        idx        <= '0;
        cand_valid <= 1'b0;
        free_valid <= 1'b0;
      end else if (state == ST_SCAN) begin
        idx <= idx + IDX_W'(1);
        if (cur_take) cand_valid <= 1'b1;
        if (!cur_valid && !free_valid) free_valid <= 1'b1;
      end else if (state == ST_FINISH && res_write) begin
        entry_valid[free_idx] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= cmd;
      mac_q  <= mac;
      port_q <= port;
    end
    if (state == ST_SCAN) begin
      if (cur_take) begin
        cand_mac  <= cur_mac;
        cand_port <= cur_port;
        cand_len  <= cur_len;
      end
      if (!cur_valid && !free_valid) free_idx <= idx;
    end
    if (state == ST_FINISH) begin
      status       <= res_status;
      out_port     <= (res_status == STATUS_FOUND) ? cand_port : '0;
      match_digits <= (res_status == STATUS_FOUND) ? len_sat : '0;
      if (res_write) begin
        entry_mac[free_idx]  <= mac_q;
        entry_port[free_idx] <= port_q;
      end
    end
  end

  // Checks
  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_FINISH))
    else $error("result strobe without a resolve cycle");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == ST_SCAN) && (idx == '0))
    else $error("accepted beat did not start a scan");

  a_insert_grows_table: assert property (@(posedge clk) disable iff (rst)
    (done && status == STATUS_INSERTED) |->
      ($countones(entry_valid) == $countones($past(entry_valid)) + 1))
    else $error("insert did not add exactly one entry");

  a_found_has_prefix: assert property (@(posedge clk) disable iff (rst)
    (done && status == STATUS_FOUND) |-> (match_digits != '0))
    else $error("found with zero-length match");

  a_other_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != STATUS_FOUND) |-> (out_port == '0) && (match_digits == '0))
    else $error("port or length set on a result other than found");

endmodule

FILE: bench/mac_port_table_prefix_lookup_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MAC port table prefix lookup testbench
// Drives assign and lookup beats into the table and checks every result
// beat against a shadow table kept in the bench. Directed beats cover the
// empty table, field extremes, conflict ordering and lookup ties. Random
// traffic is built around the stored MACs so that prefixes overlap.
// ----------------------------------------------------------------------------
module mac_port_table_prefix_lookup_tb;
  import mptl_pkg::*;

  // Expected content of one result beat
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PORT_W-1:0]   out_port;
    logic [MATCH_W-1:0]  match_digits;
  } table_answer_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic                cmd;
  logic [MAC_W-1:0]    mac;
  logic [PORT_W-1:0]   port;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [PORT_W-1:0]   out_port;
  logic [MATCH_W-1:0]  match_digits;

  // Shadow copy of the table; entries fill from slot 0 and are never freed
  logic                shadow_valid [TABLE_DEPTH];
  logic [MAC_W-1:0]    shadow_mac   [TABLE_DEPTH];
  logic [PORT_W-1:0]   shadow_port  [TABLE_DEPTH];
  int                  entries_used;

  table_answer_t       pending_answers[$];
  int                  mismatch_count;

  mac_port_table_prefix_lookup uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .mac          (mac),
    .port         (port),
    .done         (done),
    .status       (status),
    .out_port     (out_port),
    .match_digits (match_digits)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("mac_port_table_prefix_lookup_tb: FAIL");
    $finish;
  end

  // Number of equal leading hex digits of two MACs
  function automatic int common_prefix_digits(input logic [MAC_W-1:0] a,
                                              input logic [MAC_W-1:0] b);
    int n;
    n = 0;
    while (n < MAC_DIGITS &&
           a[4*(MAC_DIGITS-1-n) +: 4] == b[4*(MAC_DIGITS-1-n) +: 4])
      n++;
    return n;
  endfunction

  // Apply one command to the shadow table and work out its answer
  task automatic apply_table_command(input logic c, input logic [MAC_W-1:0] m,
                                     input logic [PORT_W-1:0] p,
                                     output table_answer_t ans);
    int i;
    int hit;
    int free_slot;
    int best;
    int best_len;
    int len;
    hit       = -1;
    free_slot = -1;
    best      = -1;
    best_len  = 0;
    ans       = '0;
    if (c == CMD_ASSIGN) begin
      // smallest conflicting MAC decides; port clash wins over MAC clash
      for (i = 0; i < TABLE_DEPTH; i++) begin
        if (!shadow_valid[i]) begin
          if (free_slot < 0) free_slot = i;
        end else if (shadow_port[i] == p || shadow_mac[i] == m) begin
          if (hit < 0 || shadow_mac[i] < shadow_mac[hit]) hit = i;
        end
      end
      if (hit >= 0) begin
        ans.status = (shadow_port[hit] == p) ? STATUS_PORT_USED : STATUS_MAC_USED;
      end else if (free_slot < 0) begin
        ans.status = STATUS_FULL;
      end else begin
        shadow_valid[free_slot] = 1'b1;
        shadow_mac[free_slot]   = m;
        shadow_port[free_slot]  = p;
        entries_used++;
        ans.status = STATUS_INSERTED;
      end
    end else begin
      // longest prefix, ties to the smaller MAC, zero length never matches
      for (i = 0; i < TABLE_DEPTH; i++) begin
        if (shadow_valid[i]) begin
          len = common_prefix_digits(m, shadow_mac[i]);
          if (len > 0 && (best < 0 || len > best_len ||
              (len == best_len && shadow_mac[i] < shadow_mac[best]))) begin
            best     = i;
            best_len = len;
          end
        end
      end
      if (best >= 0) begin
        ans.status       = STATUS_FOUND;
        ans.out_port     = shadow_port[best];
        ans.match_digits = (best_len > 15) ? 4'd15 : best_len[MATCH_W-1:0];
      end else begin
        ans.status = STATUS_NOT_FOUND;
      end
    end
  endtask

  // Present one command beat and hold it until the block takes it
  task automatic send_beat(input logic c, input logic [MAC_W-1:0] m,
                           input logic [PORT_W-1:0] p);
    table_answer_t ans;
    @(negedge clk);
    start <= 1'b1;
    cmd   <= c;
    mac   <= m;
    port  <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_table_command(c, m, p, ans);
    pending_answers.push_back(ans);
  endtask

  task automatic idle_cycles(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Sender holds off until every outstanding answer is back
  task automatic wait_all_answered();
    idle_cycles(1);
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // Result checker; done is a one-cycle strobe with no back pressure
  always @(posedge clk) begin
    table_answer_t want;
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result beat status %0d port %0d digits %0d",
                   $realtime, status, out_port, match_digits);
      end else begin
        want = pending_answers.pop_front();
        if (status !== want.status || out_port !== want.out_port ||
            match_digits !== want.match_digits) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"%0t: mismatch: expected status %0d port %0d digits %0d,",
                      " got status %0d port %0d digits %0d"},
                     $realtime, want.status, want.out_port, want.match_digits,
                     status, out_port, match_digits);
        end
      end
    end
  end

  // Lookups on an empty table
  task automatic test_empty_table();
    send_beat(CMD_LOOKUP, 48'h1234_5678_9ABC, 8'h00);
    send_beat(CMD_LOOKUP, 48'h0000_0000_0000, 8'hFF);
  endtask

  // Inserts at the field extremes and two MACs sharing a long prefix
  task automatic test_insert_extremes();
    send_beat(CMD_ASSIGN, 48'h0000_0000_0000, 8'h00);
    send_beat(CMD_ASSIGN, 48'hFFFF_FFFF_FFFF, 8'hFF);
    send_beat(CMD_ASSIGN, 48'hA000_0000_0001, 8'h10);
    send_beat(CMD_ASSIGN, 48'hA000_0000_0100, 8'h11);
  endtask

  // Conflict ordering: smallest conflicting MAC decides, port before MAC
  task automatic test_assign_conflicts();
    send_beat(CMD_ASSIGN, 48'h0000_0000_0123, 8'h00);
    send_beat(CMD_ASSIGN, 48'hFFFF_FFFF_FFFF, 8'h07);
    send_beat(CMD_ASSIGN, 48'hA000_0000_0100, 8'h10);
    send_beat(CMD_ASSIGN, 48'hA000_0000_0001, 8'h11);
    send_beat(CMD_ASSIGN, 48'hFFFF_FFFF_FFFF, 8'hFF);
  endtask

  // Exact match, no match, partial matches and ties
  task automatic test_prefix_lookups();
    send_beat(CMD_LOOKUP, 48'hFFFF_FFFF_FFFF, 8'h00);
    send_beat(CMD_LOOKUP, 48'h5555_5555_5555, 8'h00);
    send_beat(CMD_LOOKUP, 48'hA000_0000_0000, 8'h00);
    send_beat(CMD_LOOKUP, 48'hA000_0000_0F00, 8'h00);
    send_beat(CMD_LOOKUP, 48'hAFFF_FFFF_FFFF, 8'h00);
    send_beat(CMD_LOOKUP, 48'h0F00_0000_0000, 8'h00);
  endtask

  // Random traffic clustered around stored MACs and ports
  task automatic test_random_traffic(input int n_items, input int idle_pct);
    int               n;
    int               sel;
    int               keep_digits;
    logic             c;
    logic [MAC_W-1:0] m;
    logic [MAC_W-1:0] base;
    logic [MAC_W-1:0] keep_mask;
    logic [PORT_W-1:0] p;
    for (n = 0; n < n_items; n++) begin
      c = ($urandom_range(99) < 55) ? CMD_LOOKUP : CMD_ASSIGN;
      m[47:32] = 16'($urandom);
      m[31:0]  = $urandom;
      if (entries_used > 0) begin
        sel  = $urandom_range(99);
        base = shadow_mac[$urandom_range(0, entries_used - 1)];
        if (sel < 15) begin
          m = base;
        end else if (sel < 75) begin
          // keep a leading run of digits, randomize the tail
          keep_digits = $urandom_range(0, MAC_DIGITS);
          keep_mask   = {MAC_W{1'b1}} << (4 * (MAC_DIGITS - keep_digits));
          m = (base & keep_mask) | (m & ~keep_mask);
        end
      end
      p = PORT_W'($urandom_range(0, 255));
      if (entries_used > 0 && $urandom_range(99) < 25)
        p = shadow_port[$urandom_range(0, entries_used - 1)];
      send_beat(c, m, p);
      if ($urandom_range(99) < idle_pct)
        idle_cycles($urandom_range(1, 24));
    end
  endtask

  initial begin
    int guard;
    rst            = 1'b1;
    start          = 1'b0;
    cmd            = CMD_ASSIGN;
    mac            = '0;
    port           = '0;
    entries_used   = 0;
    mismatch_count = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_mac[i]   = '0;
      shadow_port[i]  = '0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_insert_extremes();
    test_assign_conflicts();
    test_prefix_lookups();

    test_random_traffic(260, 0);
    test_random_traffic(260, 50);
    wait_all_answered();
    test_random_traffic(260, 7);
    test_random_traffic(260, 0);

    // Drain, then allow for a stray late beat
    idle_cycles(1);
    guard = 0;
    while (pending_answers.size() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
    mismatch_count += pending_answers.size();

    if (mismatch_count == 0) begin
      $display("mac_port_table_prefix_lookup_tb: PASS");
    end else begin
      $display("mac_port_table_prefix_lookup_tb: FAIL");
    end
    $finish;
  end

endmodule
